// ===== design/cmap_pkg.sv =====
// Shared types, widths and codes for the character-map glyph lookup block.
`timescale 1ns / 1ps

package cmap_pkg;

  // Default store size in bytes.
  localparam int unsigned DEF_TABLE_BYTES = 65536;

  localparam int unsigned CP_W    = 21;  // code point
  localparam int unsigned GLYPH_W = 32;  // glyph index
  localparam int unsigned LEN_W   = 17;  // table_length register
  localparam int unsigned FMT_W   = 2;   // table_format register
  localparam int unsigned CFG_W   = 17;  // config write data
  localparam int unsigned OFF_W   = 36;  // byte offset into the subtable
  localparam int unsigned F4_W    = 20;  // format 4 pointers

  // Config register indexes.
  localparam logic CFG_FORMAT = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  // table_format codes.
  localparam logic [FMT_W-1:0] FMT_NONE = 2'd0;
  localparam logic [FMT_W-1:0] FMT_SEG  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_GRP  = 2'd2;

  // action codes (tuser).
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Fetch sizes.
  localparam logic [2:0] NB_HALF = 3'd2;
  localparam logic [2:0] NB_WORD = 3'd4;

  // Subtable layout.
  localparam logic [OFF_W-1:0] GRP_COUNT_OFF = 36'd12;
  localparam logic [OFF_W-1:0] GRP_BASE_OFF  = 36'd16;
  localparam logic [OFF_W-1:0] GRP_END_OFF   = 36'd4;
  localparam logic [OFF_W-1:0] GRP_FIRST_OFF = 36'd8;
  localparam logic [OFF_W-1:0] SEG_COUNT_OFF = 36'd6;
  localparam logic [F4_W-1:0]  SEG_ENDS_OFF  = 20'd14;
  localparam logic [F4_W-1:0]  SEG_STARTS_OFF = 20'd16;  // ends + reserved pad

  typedef struct packed {
    logic             start;
    logic [OFF_W-1:0] off;
    logic [2:0]       nbytes;
  } fetch_req_t;

  typedef struct packed {
    logic               done;
    logic               ok;
    logic [GLYPH_W-1:0] data;
  } fetch_rsp_t;

  typedef enum logic [1:0] {
    FT_IDLE,
    FT_CHECK,
    FT_READ,
    FT_LAST
  } ft_state_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_G_COUNT,
    S_G_MID,
    S_G_ADDR,
    S_G_START,
    S_G_END,
    S_G_FIRST,
    S_G_CMP,
    S_G_SUM,
    S_S_SEGX2,
    S_S_TBL1,
    S_S_TBL2,
    S_S_LOOP,
    S_S_END,
    S_S_START,
    S_S_DELTA,
    S_S_ROFF,
    S_S_CMP,
    S_S_PTR,
    S_S_GLYPH,
    S_DONE
  } seq_state_e;

endpackage

// ===== design/cmap_byte_store.sv =====
// Subtable byte memory: one write port, one registered read port.
`timescale 1ns / 1ps

module cmap_byte_store #(
  parameter int unsigned TABLE_BYTES = cmap_pkg::DEF_TABLE_BYTES,
  localparam int unsigned AW = $clog2(TABLE_BYTES)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [TABLE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cmap_fetch.sv =====
// Big-endian multi-byte reader with bounds check against the loaded length.
`timescale 1ns / 1ps

module cmap_fetch #(
  parameter int unsigned TABLE_BYTES = cmap_pkg::DEF_TABLE_BYTES,
  localparam int unsigned AW = $clog2(TABLE_BYTES)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cmap_pkg::LEN_W-1:0] len_i,
  input  cmap_pkg::fetch_req_t       req_i,
  output cmap_pkg::fetch_rsp_t       rsp_o,
  output logic                       re_o,
  output logic [AW-1:0]              raddr_o,
  input  logic [7:0]                 rdata_i
);

  localparam int unsigned LIM_W = (AW + 1 > cmap_pkg::LEN_W) ? AW + 1 : cmap_pkg::LEN_W;
  localparam int unsigned EW    = cmap_pkg::OFF_W + 1;
  localparam logic [LIM_W-1:0] TB_LIM = LIM_W'(TABLE_BYTES);

  cmap_pkg::ft_state_e state_q, state_d;
  logic [cmap_pkg::OFF_W-1:0] off_q, off_d;
  logic [2:0]                 n_q, n_d;
  logic [1:0]                 cnt_q, cnt_d;
  logic [23:0]                acc_q, acc_d;
  logic                       rvld_q;

  logic [LIM_W-1:0] len_ext;
  logic [LIM_W-1:0] limit;
  logic [EW-1:0]    end_off;
  logic             in_bounds;
  logic             last_issue;

  assign len_ext    = LIM_W'(len_i);
  assign limit      = (len_ext < TB_LIM) ? len_ext : TB_LIM;
  assign end_off    = {1'b0, off_q} + EW'(n_q);
  assign in_bounds  = (end_off <= EW'(limit));
  assign last_issue = ({1'b0, cnt_q} == (n_q - 3'd1));
  assign raddr_o    = off_q[AW-1:0] + AW'(cnt_q);

  always_comb begin
    state_d    = state_q;
    off_d      = off_q;
    n_d        = n_q;
    cnt_d      = cnt_q;
    acc_d      = rvld_q ? {acc_q[15:0], rdata_i} : acc_q;
    re_o       = 1'b0;
    rsp_o.done = 1'b0;
    rsp_o.ok   = 1'b0;
    rsp_o.data = {acc_q, rdata_i};
    unique case (state_q)
      cmap_pkg::FT_IDLE: begin
        if (req_i.start) begin
          off_d   = req_i.off;
          n_d     = req_i.nbytes;
          state_d = cmap_pkg::FT_CHECK;
        end
      end
      cmap_pkg::FT_CHECK: begin
        acc_d = '0;
        cnt_d = '0;
        if (in_bounds) begin
          state_d = cmap_pkg::FT_READ;
        end else begin
          rsp_o.done = 1'b1;
          state_d    = cmap_pkg::FT_IDLE;
        end
      end
      cmap_pkg::FT_READ: begin
        re_o  = 1'b1;
        cnt_d = cnt_q + 2'd1;
        if (last_issue) begin
          state_d = cmap_pkg::FT_LAST;
        end
      end
      cmap_pkg::FT_LAST: begin
        // final byte is on the read port now
        rsp_o.done = 1'b1;
        rsp_o.ok   = 1'b1;
        if (req_i.start) begin
          off_d   = req_i.off;
          n_d     = req_i.nbytes;
          state_d = cmap_pkg::FT_CHECK;
        end else begin
          state_d = cmap_pkg::FT_IDLE;
        end
      end
      default: state_d = cmap_pkg::FT_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cmap_pkg::FT_IDLE;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= re_o;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    n_q   <= n_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
  end

endmodule

// ===== design/cmap_seq.sv =====
// Lookup sequencer: format 12 binary search, format 4 segment walk, result register.
`timescale 1ns / 1ps

module cmap_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cmap_pkg::CP_W-1:0]    cp_i,
  input  logic [cmap_pkg::FMT_W-1:0]   fmt_i,
  output logic                         idle_o,
  output cmap_pkg::fetch_req_t         req_o,
  input  cmap_pkg::fetch_rsp_t         rsp_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [cmap_pkg::GLYPH_W-1:0] out_glyph_o
);

  localparam int unsigned OW = cmap_pkg::OFF_W;
  localparam int unsigned GW = cmap_pkg::GLYPH_W;
  localparam int unsigned FW = cmap_pkg::F4_W;

  cmap_pkg::seq_state_e state_q, state_d;
  logic [cmap_pkg::CP_W-1:0] cp_q, cp_d;
  logic [GW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [OW-1:0] base_q, base_d;
  logic [GW-1:0] start_q, start_d, end_q, end_d, aux_q, aux_d;
  logic [15:0]   roff_q, roff_d, segx2_q, segx2_d;
  logic [FW-1:0] starts_q, starts_d, deltas_q, deltas_d, roffs_q, roffs_d;
  logic [16:0]   i_q, i_d;
  logic [GW-1:0] res_q, res_d;
  logic          out_vld_q, out_vld_d;
  logic [GW-1:0] out_q, out_d;

  logic [GW:0]   mid_sum;
  logic [OW-1:0] grp_off;
  logic [GW-1:0] cp_ext;
  logic [15:0]   seg_diff;
  logic [15:0]   f4_sum;
  logic          fail;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  // 12 * mid + 16, as two shifted copies
  assign grp_off  = OW'({mid_q, 3'b000}) + OW'({mid_q, 2'b00}) + cmap_pkg::GRP_BASE_OFF;
  assign cp_ext   = GW'(cp_q);
  assign seg_diff = cp_q[15:0] - start_q[15:0];
  assign f4_sum   = cp_q[15:0] + aux_q[15:0];
  assign fail     = rsp_i.done && !rsp_i.ok;

  assign idle_o      = (state_q == cmap_pkg::S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_glyph_o = out_q;

  always_comb begin
    state_d  = state_q;
    cp_d     = cp_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    base_d   = base_q;
    start_d  = start_q;
    end_d    = end_q;
    aux_d    = aux_q;
    roff_d   = roff_q;
    segx2_d  = segx2_q;
    starts_d = starts_q;
    deltas_d = deltas_q;
    roffs_d  = roffs_q;
    i_d      = i_q;
    res_d    = res_q;
    out_d    = out_q;
    out_vld_d = out_vld_q && !out_ready_i;
    req_o.start  = 1'b0;
    req_o.off    = '0;
    req_o.nbytes = cmap_pkg::NB_WORD;

    if (fail) begin
      res_d   = '0;
      state_d = cmap_pkg::S_DONE;
    end else begin
      unique case (state_q)
        cmap_pkg::S_IDLE: begin
          if (start_i) begin
            cp_d = cp_i;
            if (fmt_i == cmap_pkg::FMT_GRP) begin
              req_o.start = 1'b1;
              req_o.off   = cmap_pkg::GRP_COUNT_OFF;
              state_d     = cmap_pkg::S_G_COUNT;
            end else if (fmt_i == cmap_pkg::FMT_SEG && cp_i[cmap_pkg::CP_W-1:16] == '0) begin
              req_o.start  = 1'b1;
              req_o.off    = cmap_pkg::SEG_COUNT_OFF;
              req_o.nbytes = cmap_pkg::NB_HALF;
              state_d      = cmap_pkg::S_S_SEGX2;
            end else begin
              res_d   = '0;
              state_d = cmap_pkg::S_DONE;
            end
          end
        end

        // ---- format 12 ----
        cmap_pkg::S_G_COUNT: begin
          if (rsp_i.done) begin
            lo_d    = '0;
            hi_d    = rsp_i.data;
            state_d = cmap_pkg::S_G_MID;
          end
        end
        cmap_pkg::S_G_MID: begin
          if (lo_q >= hi_q) begin
            res_d   = '0;
            state_d = cmap_pkg::S_DONE;
          end else begin
            mid_d   = mid_sum[GW:1];
            state_d = cmap_pkg::S_G_ADDR;
          end
        end
        cmap_pkg::S_G_ADDR: begin
          base_d      = grp_off;
          req_o.start = 1'b1;
          req_o.off   = grp_off;
          state_d     = cmap_pkg::S_G_START;
        end
        cmap_pkg::S_G_START: begin
          if (rsp_i.done) begin
            start_d     = rsp_i.data;
            req_o.start = 1'b1;
            req_o.off   = base_q + cmap_pkg::GRP_END_OFF;
            state_d     = cmap_pkg::S_G_END;
          end
        end
        cmap_pkg::S_G_END: begin
          if (rsp_i.done) begin
            end_d       = rsp_i.data;
            req_o.start = 1'b1;
            req_o.off   = base_q + cmap_pkg::GRP_FIRST_OFF;
            state_d     = cmap_pkg::S_G_FIRST;
          end
        end
        cmap_pkg::S_G_FIRST: begin
          if (rsp_i.done) begin
            aux_d   = rsp_i.data;
            state_d = cmap_pkg::S_G_CMP;
          end
        end
        cmap_pkg::S_G_CMP: begin
          if (cp_ext < start_q) begin
            hi_d    = mid_q;
            state_d = cmap_pkg::S_G_MID;
          end else if (cp_ext > end_q) begin
            lo_d    = mid_q + GW'(1);
            state_d = cmap_pkg::S_G_MID;
          end else begin
            res_d   = cp_ext - start_q;
            state_d = cmap_pkg::S_G_SUM;
          end
        end
        cmap_pkg::S_G_SUM: begin
          res_d   = res_q + aux_q;  // wraps mod 2^32
          state_d = cmap_pkg::S_DONE;
        end

        // ---- format 4 ----
        cmap_pkg::S_S_SEGX2: begin
          if (rsp_i.done) begin
            segx2_d  = rsp_i.data[15:0];
            starts_d = cmap_pkg::SEG_STARTS_OFF + FW'(rsp_i.data[15:0]);
            state_d  = cmap_pkg::S_S_TBL1;
          end
        end
        cmap_pkg::S_S_TBL1: begin
          deltas_d = starts_q + FW'(segx2_q);
          state_d  = cmap_pkg::S_S_TBL2;
        end
        cmap_pkg::S_S_TBL2: begin
          roffs_d = deltas_q + FW'(segx2_q);
          i_d     = '0;
          state_d = cmap_pkg::S_S_LOOP;
        end
        cmap_pkg::S_S_LOOP: begin
          if (i_q >= {1'b0, segx2_q}) begin
            res_d   = '0;
            state_d = cmap_pkg::S_DONE;
          end else begin
            req_o.start  = 1'b1;
            req_o.off    = OW'(cmap_pkg::SEG_ENDS_OFF + FW'(i_q));
            req_o.nbytes = cmap_pkg::NB_HALF;
            state_d      = cmap_pkg::S_S_END;
          end
        end
        cmap_pkg::S_S_END: begin
          if (rsp_i.done) begin
            end_d        = rsp_i.data;
            req_o.start  = 1'b1;
            req_o.off    = OW'(starts_q + FW'(i_q));
            req_o.nbytes = cmap_pkg::NB_HALF;
            state_d      = cmap_pkg::S_S_START;
          end
        end
        cmap_pkg::S_S_START: begin
          if (rsp_i.done) begin
            start_d      = rsp_i.data;
            req_o.start  = 1'b1;
            req_o.off    = OW'(deltas_q + FW'(i_q));
            req_o.nbytes = cmap_pkg::NB_HALF;
            state_d      = cmap_pkg::S_S_DELTA;
          end
        end
        cmap_pkg::S_S_DELTA: begin
          if (rsp_i.done) begin
            aux_d        = rsp_i.data;
            req_o.start  = 1'b1;
            req_o.off    = OW'(roffs_q + FW'(i_q));
            req_o.nbytes = cmap_pkg::NB_HALF;
            state_d      = cmap_pkg::S_S_ROFF;
          end
        end
        cmap_pkg::S_S_ROFF: begin
          if (rsp_i.done) begin
            roff_d  = rsp_i.data[15:0];
            state_d = cmap_pkg::S_S_CMP;
          end
        end
        cmap_pkg::S_S_CMP: begin
          if (cp_ext > end_q) begin
            i_d     = i_q + 17'd2;
            state_d = cmap_pkg::S_S_LOOP;
          end else if (cp_ext < start_q) begin
            res_d   = '0;
            state_d = cmap_pkg::S_DONE;
          end else if (roff_q == '0) begin
            res_d   = GW'(f4_sum);
            state_d = cmap_pkg::S_DONE;
          end else begin
            base_d  = OW'(roffs_q) + OW'(i_q) + OW'(roff_q);
            state_d = cmap_pkg::S_S_PTR;
          end
        end
        cmap_pkg::S_S_PTR: begin
          req_o.start  = 1'b1;
          req_o.off    = base_q + OW'({seg_diff, 1'b0});
          req_o.nbytes = cmap_pkg::NB_HALF;
          state_d      = cmap_pkg::S_S_GLYPH;
        end
        cmap_pkg::S_S_GLYPH: begin
          if (rsp_i.done) begin
            if (rsp_i.data[15:0] == '0) begin
              res_d = '0;
            end else begin
              res_d = GW'(16'(rsp_i.data[15:0] + aux_q[15:0]));
            end
            state_d = cmap_pkg::S_DONE;
          end
        end

        cmap_pkg::S_DONE: begin
          if (!out_vld_q || out_ready_i) begin
            out_vld_d = 1'b1;
            out_d     = res_q;
            state_d   = cmap_pkg::S_IDLE;
          end
        end
        default: state_d = cmap_pkg::S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cmap_pkg::S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q     <= cp_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    base_q   <= base_d;
    start_q  <= start_d;
    end_q    <= end_d;
    aux_q    <= aux_d;
    roff_q   <= roff_d;
    segx2_q  <= segx2_d;
    starts_q <= starts_d;
    deltas_q <= deltas_d;
    roffs_q  <= roffs_d;
    i_q      <= i_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

endmodule

// ===== design/cmap_codepoint_to_glyph.sv =====
// Top level: cmap subtable byte store with format 4 / format 12 glyph lookup.
`timescale 1ns / 1ps
// Load transfer: accepted when idle, byte written at the edge of the transfer, no result.
// Lookup: each n-byte fetch holds the single read port for a check, n reads and a collect step.
//   Format 12: the result follows the transfer after a binary search over the groups,
//   up to 32 probes. Format 4: a walk over the segments, one extra fetch on the offset path.
// One lookup at a time; a finished result sits in the output register so the next
// transfer is taken while it waits. Reset clears config and control; the store is not cleared.

module cmap_codepoint_to_glyph #(
  parameter int unsigned TABLE_BYTES = cmap_pkg::DEF_TABLE_BYTES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [cmap_pkg::CFG_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [47:0]                s_axis_tdata,  // byte_address[15:0], byte_value[23:16],
                                                    // code_point[44:24], zero pad
  input  logic                       s_axis_tuser,  // action
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata   // glyph_index
);

  localparam int unsigned AW  = $clog2(TABLE_BYTES);
  localparam int unsigned WAW = (AW > 16) ? AW : 16;
  localparam logic [WAW:0] TB_W = (WAW + 1)'(TABLE_BYTES);

  // config registers
  logic [cmap_pkg::FMT_W-1:0] fmt_q;
  logic [cmap_pkg::LEN_W-1:0] len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= cmap_pkg::FMT_NONE;
      len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cmap_pkg::CFG_FORMAT: fmt_q <= cfg_wdata_i[cmap_pkg::FMT_W-1:0];
        cmap_pkg::CFG_LENGTH: len_q <= cfg_wdata_i[cmap_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic [15:0]               in_addr;
  logic [7:0]                in_byte;
  logic [cmap_pkg::CP_W-1:0] in_cp;
  logic                      in_xfer;
  logic [WAW-1:0]            wr_addr;
  logic                      wr_en;
  logic                      lookup_go;
  logic                      seq_idle;

  assign in_addr = s_axis_tdata[15:0];
  assign in_byte = s_axis_tdata[23:16];
  assign in_cp   = s_axis_tdata[44:24];

  assign s_axis_tready = seq_idle;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign wr_addr       = WAW'(in_addr);
  // loads past the end of the store are dropped
  assign wr_en         = in_xfer && (s_axis_tuser == cmap_pkg::ACT_LOAD)
                         && ({1'b0, wr_addr} < TB_W);
  assign lookup_go     = in_xfer && (s_axis_tuser == cmap_pkg::ACT_LOOKUP);

  // store, fetch unit, sequencer
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  cmap_pkg::fetch_req_t f_req;
  cmap_pkg::fetch_rsp_t f_rsp;

  cmap_byte_store #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr[AW-1:0]),
    .wdata_i(in_byte),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  cmap_fetch #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_fetch (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .len_i  (len_q),
    .req_i  (f_req),
    .rsp_o  (f_rsp),
    .re_o   (rd_en),
    .raddr_o(rd_addr),
    .rdata_i(rd_data)
  );

  cmap_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (lookup_go),
    .cp_i       (in_cp),
    .fmt_i      (fmt_q),
    .idle_o     (seq_idle),
    .req_o      (f_req),
    .rsp_i      (f_rsp),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_glyph_o(m_axis_tdata)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for the cmap code point to glyph lookup block.
`timescale 1ns / 1ps

module tb;
  import cmap_pkg::*;

  localparam int unsigned STORE_BYTES  = DEF_TABLE_BYTES;
  localparam int unsigned STALL_LIMIT  = 20000;  // cycles with no transfer on either side
  localparam int unsigned RANDOM_ITEMS = 1250;   // directed tests and the last round add the rest
  localparam int unsigned HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int unsigned IDLE_PCT     = 24;
  localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;  // unused selector, must act as no table

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic                 cfg_idx_i     = CFG_FORMAT;
  logic [CFG_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata  = '0;  // byte_address, byte_value, code_point, pad
  logic                 s_axis_tuser  = ACT_LOAD;  // action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [31:0]          m_axis_tdata;  // glyph_index

  cmap_codepoint_to_glyph #(.TABLE_BYTES(STORE_BYTES)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the block: byte store, which bytes were ever loaded, registers.
  // ---------------------------------------------------------------------------
  logic [7:0]       shadow_bytes   [0:STORE_BYTES-1];
  bit               shadow_written [0:STORE_BYTES-1];
  logic [FMT_W-1:0] shadow_format = FMT_NONE;
  logic [LEN_W-1:0] shadow_length = '0;
  bit               blank_read;  // set when a lookup would touch a never-loaded byte

  logic [31:0] pending_glyphs [$];  // expected glyph per accepted lookup, oldest first
  logic [31:0] range_lo [$];        // code ranges of the current table, used to aim lookups
  logic [31:0] range_hi [$];

  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned quiet_cycles   = 0;
  bit          tx_calm        = 1'b0;
  bit          rx_calm        = 1'b0;
  int unsigned hold_ask       = 0;  // bumped by the stimulus to request a hold-off
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  // Big-endian read of n bytes; fails unless it lies wholly inside the valid length,
  // which is capped by the store size.
  function automatic bit pull_be(input longint unsigned off, input int unsigned n,
                                 output logic [31:0] v);
    longint unsigned lim;
    logic [31:0]     acc;
    int unsigned     k;
    lim = (shadow_length < STORE_BYTES) ? shadow_length : STORE_BYTES;
    v   = '0;
    acc = '0;
    if (off > lim || n > lim - off) return 1'b0;
    for (k = 0; k < n; k++) begin
      if (!shadow_written[off + k]) blank_read = 1'b1;
      acc = (acc << 8) | shadow_bytes[off + k];
    end
    v = acc;
    return 1'b1;
  endfunction

  // Format 12: binary search over (start, end, start glyph) groups.
  function automatic logic [31:0] find_in_groups(input logic [31:0] cp);
    logic [31:0]     cnt, lo_c, hi_c, first;
    longint unsigned lo, hi, mid, g;
    if (!pull_be(GRP_COUNT_OFF, 4, cnt)) return '0;
    lo = 0;
    hi = cnt;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      g   = GRP_BASE_OFF + 12 * mid;
      if (!pull_be(g, 4, lo_c) || !pull_be(g + GRP_END_OFF, 4, hi_c)
          || !pull_be(g + GRP_FIRST_OFF, 4, first))
        return '0;
      if (cp < lo_c) hi = mid;
      else if (cp > hi_c) lo = mid + 1;
      else return first + (cp - lo_c);  // wraps mod 2^32
    end
    return '0;
  endfunction

  // Format 4: walk segments in order; direct delta or range-offset indirection.
  function automatic logic [31:0] find_in_segments(input logic [31:0] cp);
    logic [31:0]     segx2, e_code, s_code, delta, rof, gv;
    longint unsigned starts, deltas, roffs, i, p;
    if (cp > 32'hFFFF) return '0;
    if (!pull_be(SEG_COUNT_OFF, 2, segx2)) return '0;
    starts = SEG_ENDS_OFF + segx2 + 2;
    deltas = starts + segx2;
    roffs  = deltas + segx2;
    for (i = 0; i < segx2; i += 2) begin
      if (!pull_be(SEG_ENDS_OFF + i, 2, e_code) || !pull_be(starts + i, 2, s_code)
          || !pull_be(deltas + i, 2, delta) || !pull_be(roffs + i, 2, rof))
        return '0;
      if (cp <= e_code) begin
        if (cp < s_code) return '0;
        if (rof == 0) return {16'b0, cp[15:0] + delta[15:0]};
        p = roffs + i + rof + 2 * (cp - s_code);
        if (!pull_be(p, 2, gv)) return '0;
        if (gv == 0) return '0;
        return {16'b0, gv[15:0] + delta[15:0]};
      end
    end
    return '0;
  endfunction

  function automatic logic [31:0] map_codepoint(input logic [CP_W-1:0] cp);
    case (shadow_format)
      FMT_SEG: return find_in_segments({11'b0, cp});
      FMT_GRP: return find_in_groups({11'b0, cp});
      default: return '0;  // no table, and the spare selector
    endcase
  endfunction

  // Mostly inside a known range, some just off either edge, some anywhere.
  function automatic logic [CP_W-1:0] pick_code();
    int unsigned r, k;
    logic [31:0] lo, hi, v;
    r = $urandom_range(99);
    v = $urandom;
    if (range_lo.size() == 0 || r >= 85) return v[CP_W-1:0];
    k  = $urandom_range(range_lo.size() - 1);
    lo = range_lo[k];
    hi = range_hi[k];
    if (r < 8) v = lo - 1;
    else if (r < 16) v = hi + 1;
    else v = lo + (v % (hi - lo + 1));
    return v[CP_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, calm stretches, and on request a long hold-off.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else if (rx_calm) begin
      m_axis_tready = 1'b1;
    end else begin
      m_axis_tready = ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Every result transfer is matched against the oldest pending glyph.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_glyphs.size() == 0)
        flag_mismatch("result with no lookup pending", m_axis_tdata, '0);
      else if (m_axis_tdata !== pending_glyphs[0])
        flag_mismatch("glyph_index", m_axis_tdata, pending_glyphs.pop_front());
      else
        void'(pending_glyphs.pop_front());
    end
  end

  // Watchdog: too long without any transfer means the block hung.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them start and finish just after a falling edge.
  // ---------------------------------------------------------------------------

  // Register write, only ever issued while the block is idle.
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_FORMAT) shadow_format = val[FMT_W-1:0];
    else shadow_length = val[LEN_W-1:0];
  endtask

  // One input transfer. A lookup that would read a never-loaded byte is dropped.
  // tvalid stays high on return so back-to-back items need no extra toggle.
  task automatic send_item(input logic act, input logic [15:0] addr,
                           input logic [7:0] val, input logic [CP_W-1:0] cp);
    logic [31:0] want;
    want = '0;
    if (act == ACT_LOOKUP) begin
      blank_read = 1'b0;
      want       = map_codepoint(cp);
      if (blank_read) return;
    end else begin
      shadow_bytes[addr]   = val;
      shadow_written[addr] = 1'b1;
    end
    if (!tx_calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tdata  = {3'b0, cp, val, addr};
    s_axis_tuser  = act;
    s_axis_tvalid = 1'b1;
    if (act == ACT_LOOKUP) pending_glyphs.push_back(want);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic put_byte(input int unsigned a, input logic [7:0] v);
    logic [31:0] at, r;
    at = a;
    r  = $urandom;  // unused code point field carries junk
    send_item(ACT_LOAD, at[15:0], v, r[CP_W-1:0]);
  endtask

  task automatic put_be16(input int unsigned a, input logic [15:0] v);
    put_byte(a, v[15:8]);
    put_byte(a + 1, v[7:0]);
  endtask

  task automatic put_be32(input int unsigned a, input logic [31:0] v);
    put_be16(a, v[31:16]);
    put_be16(a + 2, v[15:0]);
  endtask

  task automatic look_up(input logic [CP_W-1:0] cp);
    logic [31:0] r;
    r = $urandom;  // unused address and byte fields carry junk
    send_item(ACT_LOOKUP, r[15:0], r[23:16], cp);
  endtask

  // Stop offering, wait for every pending glyph, then let a trailing load finish.
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending_glyphs.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Random format 12 table: sorted groups, sometimes a count that overruns them.
  task automatic build_groups(output int unsigned size);
    int unsigned n, k, cnt;
    logic [31:0] code, lo, hi, first;
    range_lo.delete();
    range_hi.delete();
    n    = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 30);
    code = ($urandom_range(3) == 0) ? 32'h001F_0000 + $urandom_range(0, 4000)
                                    : $urandom_range(0, 2000);
    for (k = 0; k < n; k++) begin
      lo    = code;
      hi    = lo + $urandom_range(0, 40);
      first = $urandom;
      if ($urandom_range(7) == 0) first = 32'hFFFF_FFFF - $urandom_range(0, 20);
      put_be32(16 + 12 * k, lo);
      put_be32(20 + 12 * k, hi);
      put_be32(24 + 12 * k, first);
      range_lo.push_back(lo);
      range_hi.push_back(hi);
      code = hi + 1 + $urandom_range(0, 60);
    end
    cnt = ($urandom_range(9) == 0) ? n + $urandom_range(1, 5) : n;
    put_be32(GRP_COUNT_OFF, cnt);
    size = 16 + 12 * n;
  endtask

  // Random format 4 table. An odd segCountX2 still walks nseg segments and
  // makes the arrays overlap by a byte; the shadow store follows whatever lands.
  task automatic build_segments(output int unsigned size);
    int unsigned nseg, segx2, k, j, span, starts, deltas, roffs, gbase, gcount;
    logic [31:0] code, lo, hi, delta, rof, gv;
    range_lo.delete();
    range_hi.delete();
    nseg  = $urandom_range(1, 24);
    segx2 = 2 * nseg;
    if ($urandom_range(6) == 0) segx2 = segx2 - 1;
    if ($urandom_range(19) == 0) begin
      nseg  = 0;
      segx2 = 0;
    end
    starts = SEG_STARTS_OFF + segx2;
    deltas = starts + segx2;
    roffs  = deltas + segx2;
    gbase  = roffs + 2 * nseg;
    gcount = 0;
    code   = $urandom_range(0, 300);
    for (k = 0; k < nseg; k++) begin
      lo = code;
      hi = lo + $urandom_range(0, 6);
      if (k == nseg - 1 && $urandom_range(1) == 1) begin
        lo = 32'hFFFF;  // usual terminator segment
        hi = 32'hFFFF;
      end
      delta = $urandom_range(0, 16'hFFFF);
      rof   = '0;
      if ($urandom_range(1) == 1) begin
        rof  = gbase + 2 * gcount - (roffs + 2 * k);
        span = hi - lo + 1;
        for (j = 0; j < span; j++) begin
          gv = ($urandom_range(7) == 0) ? 32'h0 : $urandom_range(1, 16'hFFFF);
          put_be16(gbase + 2 * (gcount + j), gv[15:0]);
        end
        gcount += span;
      end
      put_be16(SEG_ENDS_OFF + 2 * k, hi[15:0]);
      put_be16(starts + 2 * k, lo[15:0]);
      put_be16(deltas + 2 * k, delta[15:0]);
      put_be16(roffs + 2 * k, rof[15:0]);
      range_lo.push_back(lo);
      range_hi.push_back(hi);
      code = hi + 1 + $urandom_range(0, 40);
    end
    put_be16(SEG_COUNT_OFF, segx2[15:0]);
    size = gbase + 2 * gcount;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No table, the spare selector, and zero length: every lookup answers 0
  // without touching the store.
  task automatic test_no_table();
    settle();
    write_reg(CFG_FORMAT, CFG_W'(FMT_NONE));
    write_reg(CFG_LENGTH, '0);
    look_up('0);
    look_up({CP_W{1'b1}});
    settle();
    write_reg(CFG_FORMAT, CFG_W'(FMT_SPARE));
    look_up(21'h00041);
    settle();
    write_reg(CFG_FORMAT, CFG_W'(FMT_GRP));
    look_up(21'h00041);
    settle();
    write_reg(CFG_FORMAT, CFG_W'(FMT_SEG));
    look_up(21'h00041);
  endtask

  // Three groups: edges, gaps, the top code point, and a start glyph that wraps.
  task automatic test_groups_directed();
    logic [31:0]     grp [9];
    logic [CP_W-1:0] probe [8];
    int unsigned     k;
    grp   = '{32'h20, 32'h7E, 32'h1, 32'h4E00, 32'h9FFF, 32'hFFFF_FFF0,
              32'h1F600, 32'h1FFFFF, 32'd500};
    probe = '{21'h0, 21'h20, 21'h7E, 21'h7F, 21'h4E00, 21'h4E20, 21'h1F5FF, 21'h1FFFFF};
    settle();
    write_reg(CFG_FORMAT, CFG_W'(FMT_GRP));
    write_reg(CFG_LENGTH, CFG_W'(52));
    put_be32(GRP_COUNT_OFF, 32'd3);
    for (k = 0; k < 9; k++) put_be32(GRP_BASE_OFF + 4 * k, grp[k]);
    for (k = 0; k < 8; k++) look_up(probe[k]);
    // huge count: the first probe lands far outside the loaded bytes
    put_be32(GRP_COUNT_OFF, 32'hFFFF_FFFF);
    look_up(21'h30);
    put_be32(GRP_COUNT_OFF, 32'd3);
    // last start-glyph word cut off by one byte
    settle();
    write_reg(CFG_LENGTH, CFG_W'(51));
    look_up(21'h1FFFFF);
    settle();
    write_reg(CFG_LENGTH, CFG_W'(52));
    range_lo.delete();
    range_hi.delete();
    for (k = 0; k < 3; k++) begin
      range_lo.push_back(grp[3 * k]);
      range_hi.push_back(grp[3 * k + 1]);
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering lookups,
  // so the output register fills and the input stalls.
  task automatic test_output_backpressure();
    settle();
    tx_calm = 1'b1;
    hold_ask++;
    repeat (30) look_up(pick_code());
    tx_calm = 1'b0;
  endtask

  // Three segments: delta wrap, indirection with a zero glyph and a wrapping sum,
  // terminator, code point above 16 bits, and a glyph word cut off by the length.
  task automatic test_segments_directed();
    logic [15:0]     words [17];
    logic [CP_W-1:0] probe [11];
    int unsigned     k;
    // ends, pad, starts, deltas, range offsets, glyph array (from byte 14 on)
    words = '{16'h0027, 16'h0103, 16'hFFFF, 16'h0000,
              16'h0020, 16'h0100, 16'hFFFF,
              16'hFFE3, 16'h0010, 16'h0001,
              16'h0000, 16'h0004, 16'h0000,
              16'h0000, 16'h1234, 16'hFFFF, 16'h0042};
    probe = '{21'h20, 21'h27, 21'h1F, 21'h28, 21'h100, 21'h101, 21'h102, 21'h103,
              21'hFFFF, 21'h10000, 21'h1FFFFF};
    settle();
    write_reg(CFG_FORMAT, CFG_W'(FMT_SEG));
    write_reg(CFG_LENGTH, CFG_W'(48));
    put_be16(SEG_COUNT_OFF, 16'd6);
    for (k = 0; k < 17; k++) put_be16(SEG_ENDS_OFF + 2 * k, words[k]);
    for (k = 0; k < 11; k++) look_up(probe[k]);
    settle();
    write_reg(CFG_LENGTH, CFG_W'(47));
    look_up(21'h103);
    look_up(21'h101);
  endtask

  // Indirection pointing at the last two store bytes; lengths at and past the
  // store size must both stop reads at the store's end.
  task automatic test_store_limit();
    settle();
    write_reg(CFG_FORMAT, CFG_W'(FMT_SEG));
    write_reg(CFG_LENGTH, CFG_W'(STORE_BYTES));
    put_be16(SEG_COUNT_OFF, 16'd2);
    put_be16(14, 16'h0012);  // end
    put_be16(18, 16'h0010);  // start
    put_be16(20, 16'h0000);  // delta
    put_be16(22, 16'd65512); // range offset: glyph word at the last two bytes
    put_be16(STORE_BYTES - 2, 16'h1234);
    look_up(21'h10);
    look_up(21'h11);
    settle();
    write_reg(CFG_LENGTH, {CFG_W{1'b1}});
    look_up(21'h10);
    look_up(21'h12);
    settle();
    write_reg(CFG_LENGTH, CFG_W'(STORE_BYTES - 1));
    look_up(21'h10);
  endtask

  // One phase: new format and table, a length mostly near the table size, then lookups
  // aimed at the table with a sprinkle of stray loads.
  task automatic run_random_round();
    int unsigned      kind, size, n, r;
    logic [FMT_W-1:0] fmt;
    logic [CFG_W-1:0] len;
    logic [31:0]      raw, at;
    settle();
    kind = $urandom_range(9);
    if (kind == 0) fmt = ($urandom_range(1) == 1) ? FMT_SPARE : FMT_NONE;
    else if (kind < 5) fmt = FMT_SEG;
    else fmt = FMT_GRP;
    write_reg(CFG_FORMAT, CFG_W'(fmt));
    if (fmt == FMT_SEG || (fmt != FMT_GRP && $urandom_range(1) == 1)) build_segments(size);
    else build_groups(size);
    r = $urandom_range(99);
    if (r < 70) len = size[CFG_W-1:0];
    else if (r < 85) len = (size > 12) ? CFG_W'(size - $urandom_range(1, 12)) : '0;
    else if (r < 95) len = CFG_W'(size + $urandom_range(1, 64));
    else len = ($urandom_range(1) == 1) ? {CFG_W{1'b1}} : CFG_W'(STORE_BYTES);
    settle();
    write_reg(CFG_LENGTH, len);
    n = $urandom_range(20, 60);
    repeat (n) begin
      if ($urandom_range(9) == 0) begin
        raw = $urandom;
        at  = raw[31] ? {16'b0, raw[15:0]} : {16'b0, raw[15:0]} % (size + 16);
        put_byte(at, raw[23:16]);
      end else begin
        look_up(pick_code());
      end
    end
  endtask

  task automatic test_random_tables();
    int unsigned first_item;
    first_item = items_sent;
    // first phase runs without any idling on either side
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    run_random_round();
    settle();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    while (items_sent - first_item < RANDOM_ITEMS) run_random_round();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_no_table();
    test_groups_directed();
    test_output_backpressure();
    test_segments_directed();
    test_store_limit();
    test_random_tables();
    settle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
design/cmap_pkg.sv
design/cmap_byte_store.sv
design/cmap_fetch.sv
design/cmap_seq.sv
design/cmap_codepoint_to_glyph.sv
verif/tb.sv
